// ----- hw/rtl/dmpht_pkg.sv -----
// dmpht_pkg: shared constants, codes, word types and inter-module structs
// for the direct-mapped pid hash table; no dependencies

package dmpht_pkg;

  // table geometry
  localparam int MAX_LOG_SLOTS = 10;
  localparam int SLOT_BITS     = MAX_LOG_SLOTS;
  localparam int NUM_SLOTS     = 1 << MAX_LOG_SLOTS;
  localparam int ACCOUNT_WIDTH = 64;

  // fixed field widths
  localparam int ACTION_WIDTH     = 2;
  localparam int PID_WIDTH        = 23;
  localparam int ACCT_FIELD_WIDTH = 64;
  localparam int HASH_WIDTH       = 32;
  localparam int SEED_WIDTH       = 32;
  localparam int LOG_SIZE_WIDTH   = 4;
  localparam int LS_WIDTH         = LOG_SIZE_WIDTH + 1;
  localparam int CFG_INDEX_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH   = 32;

  // action codes; the unused code behaves as a get
  localparam logic [ACTION_WIDTH-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_GET    = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_REMOVE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HASH_SEED = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LOG_SIZE  = 1'd1;

  localparam logic [SEED_WIDTH-1:0]     SEED_RESET     = '0;
  localparam logic [LOG_SIZE_WIDTH-1:0] LOG_SIZE_RESET = 4'd10;

  // murmur3 x86_32 constants
  localparam logic [HASH_WIDTH-1:0] HASH_C1  = 32'hcc9e2d51;
  localparam logic [HASH_WIDTH-1:0] HASH_C2  = 32'h1b873593;
  localparam logic [HASH_WIDTH-1:0] HASH_ADD = 32'he6546b64;
  localparam logic [HASH_WIDTH-1:0] HASH_LEN = 32'h00000004;
  localparam logic [HASH_WIDTH-1:0] HASH_F1  = 32'h85ebca6b;
  localparam logic [HASH_WIDTH-1:0] HASH_F2  = 32'hc2b2ae35;

  typedef struct packed {
    logic [ACTION_WIDTH-1:0]     action;
    logic [PID_WIDTH-1:0]        key_pid;
    logic [PID_WIDTH-1:0]        entry_pid;
    logic [ACCT_FIELD_WIDTH-1:0] entry_account;
  } req_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]        slot_index;
    logic [PID_WIDTH-1:0]        found_pid;
    logic [ACCT_FIELD_WIDTH-1:0] found_account;
    logic                        collision;
  } rsp_t;

  // lookup launched into the table
  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] index;
    req_t                 req;
  } look_t;

  // clearing sweep write
  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] addr;
  } clr_t;

endpackage

// ----- hw/rtl/direct_mapped_pid_hash_table_unit.sv -----
// direct_mapped_pid_hash_table_unit: top level of the pid hash table
// depends on dmpht_pkg, dmpht_hash and dmpht_table
//
//  channel  | handshake               | word
//  ---------+-------------------------+-------------------------------------
//  req      | req_valid / req_stall   | req  (action, key_pid, entry_*)
//  rsp      | rsp_valid / rsp_stall   | rsp  (slot_index, found_*, collision)
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one request word is in flight at a time; from acceptance the word passes
// through the hash pipeline, the registered memory read, modify and
// write-back, and the output register. the next request is taken once
// the result has entered the output register, so a new word never starts
// before the last one has left the table.
// after reset the table is swept to zero with req stalled.
// a stalled result waits in the output register while the next word starts.

module direct_mapped_pid_hash_table_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  dmpht_pkg::req_t                       req,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output dmpht_pkg::rsp_t                       rsp,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dmpht_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [dmpht_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  // configuration registers
  logic [dmpht_pkg::SEED_WIDTH-1:0]     hash_seed;
  logic [dmpht_pkg::LOG_SIZE_WIDTH-1:0] log_size;

  // control
  logic                             busy;
  logic [dmpht_pkg::SLOT_BITS:0]    clr_cnt;
  logic                             clearing;
  logic                             accept;
  dmpht_pkg::req_t                  req_q;

  // hash and table hookup
  logic                             hash_done;
  logic [dmpht_pkg::HASH_WIDTH-1:0] hash;
  logic [dmpht_pkg::LS_WIDTH-1:0]   ls;
  logic [dmpht_pkg::SLOT_BITS-1:0]  slot_mask;
  dmpht_pkg::look_t                 look;
  dmpht_pkg::clr_t                  clr;
  logic                             res_valid;
  dmpht_pkg::rsp_t                  res;
  logic                             res_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= dmpht_pkg::SEED_RESET;
      log_size  <= dmpht_pkg::LOG_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dmpht_pkg::CFG_HASH_SEED: hash_seed <= cfg_data;
        dmpht_pkg::CFG_LOG_SIZE:  log_size  <= cfg_data[dmpht_pkg::LOG_SIZE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // clearing sweep after reset, top bit set when done
  assign clearing = !clr_cnt[dmpht_pkg::SLOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign clr.en   = clearing;
  assign clr.addr = clr_cnt[dmpht_pkg::SLOT_BITS-1:0];

  // request side: one word in flight until its result leaves the table
  assign req_stall = busy || clearing;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (res_take) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  dmpht_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (dmpht_pkg::HASH_WIDTH'(req.key_pid)),
    .seed  (hash_seed),
    .done  (hash_done),
    .hash  (hash)
  );

  // log size clamped to 1..MAX_LOG_SLOTS, then a low-bit mask
  always_comb begin
    if (log_size == '0) begin
      ls = dmpht_pkg::LS_WIDTH'(1);
    end else if (dmpht_pkg::LS_WIDTH'(log_size) >
                 dmpht_pkg::LS_WIDTH'(dmpht_pkg::MAX_LOG_SLOTS)) begin
      ls = dmpht_pkg::LS_WIDTH'(dmpht_pkg::MAX_LOG_SLOTS);
    end else begin
      ls = dmpht_pkg::LS_WIDTH'(log_size);
    end
    for (int i = 0; i < dmpht_pkg::SLOT_BITS; i++) begin
      slot_mask[i] = dmpht_pkg::LS_WIDTH'(i) < ls;
    end
  end

  assign look.en    = hash_done;
  assign look.index = hash[dmpht_pkg::SLOT_BITS-1:0] & slot_mask;
  assign look.req   = req_q;

  dmpht_table u_table (
    .clk       (clk),
    .rst       (rst),
    .look      (look),
    .clr       (clr),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register: loads when empty or being drained
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

  a_res_busy: assert property (@(posedge clk) disable iff (rst) res_valid |-> busy)
    else $error("table result without a request in flight");

  a_hash_busy: assert property (@(posedge clk) disable iff (rst)
      hash_done |-> (busy && !clearing))
    else $error("hash finished outside a request");

endmodule

// ----- hw/rtl/dmpht_hash.sv -----
// dmpht_hash: five-stage pipelined murmur3 x86_32 of one 32-bit key
// depends on dmpht_pkg

module dmpht_hash (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dmpht_pkg::HASH_WIDTH-1:0] key,
  input  logic [dmpht_pkg::SEED_WIDTH-1:0] seed,
  output logic                             done,
  output logic [dmpht_pkg::HASH_WIDTH-1:0] hash
);

  logic [4:0] vld;
  logic [dmpht_pkg::HASH_WIDTH-1:0] k1, k2, h3, h4, h5;
  logic [dmpht_pkg::HASH_WIDTH-1:0] k1_rot, h_mix, h_rot, h3_next, t4, t5;

  // body block: k rotated by 15, h rotated by 13 then times 5 plus add
  assign k1_rot  = {k1[16:0], k1[31:17]};
  assign h_mix   = seed ^ k2;
  assign h_rot   = {h_mix[18:0], h_mix[31:19]};
  assign h3_next = {h_rot[29:0], 2'b00} + h_rot + dmpht_pkg::HASH_ADD;

  // finalization
  assign t4 = (h3 ^ dmpht_pkg::HASH_LEN) ^ {16'h0000, h3[31:16] ^ dmpht_pkg::HASH_LEN[31:16]};
  assign t5 = h4 ^ {13'h0000, h4[31:13]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    k1 <= key * dmpht_pkg::HASH_C1;
    k2 <= k1_rot * dmpht_pkg::HASH_C2;
    h3 <= h3_next;
    h4 <= t4 * dmpht_pkg::HASH_F1;
    h5 <= t5 * dmpht_pkg::HASH_F2;
  end

  assign done = vld[4];
  assign hash = h5 ^ {16'h0000, h5[31:16]};

  // one key at a time in the pipe
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst) $onehot0(vld))
    else $error("more than one key in the hash pipeline");

endmodule

// ----- hw/rtl/dmpht_table.sv -----
// dmpht_table: slot memories for pid and account with read-modify-write
// of add, get and remove, plus the clearing sweep port; depends on dmpht_pkg

module dmpht_table (
  input  logic              clk,
  input  logic              rst,
  input  dmpht_pkg::look_t  look,
  input  dmpht_pkg::clr_t   clr,
  input  logic              res_take,
  output logic              res_valid,
  output dmpht_pkg::rsp_t   res
);

  logic [dmpht_pkg::PID_WIDTH-1:0]     mem_pid [dmpht_pkg::NUM_SLOTS];
  logic [dmpht_pkg::ACCOUNT_WIDTH-1:0] mem_acct[dmpht_pkg::NUM_SLOTS];

  logic                                vld_a;
  dmpht_pkg::req_t                     req_a;
  logic [dmpht_pkg::SLOT_BITS-1:0]     idx_a;
  logic [dmpht_pkg::PID_WIDTH-1:0]     rd_pid;
  logic [dmpht_pkg::ACCOUNT_WIDTH-1:0] rd_acct;

  logic                                wr_b, wr_zero_b;
  logic                                wr_en;
  logic [dmpht_pkg::SLOT_BITS-1:0]     wr_addr;
  logic [dmpht_pkg::PID_WIDTH-1:0]     wr_pid;
  logic [dmpht_pkg::ACCOUNT_WIDTH-1:0] wr_acct;
  dmpht_pkg::rsp_t                     res_next;

  // read stage
  always_ff @(posedge clk) begin
    if (look.en) begin
      rd_pid  <= mem_pid[look.index];
      rd_acct <= mem_acct[look.index];
    end
    req_a <= look.req;
    idx_a <= look.index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else begin
      vld_a <= look.en;
    end
  end

  // modify stage
  always_comb begin
    wr_b      = 1'b0;
    wr_zero_b = 1'b0;
    res_next  = '0;
    res_next.slot_index = idx_a;
    case (req_a.action)
      dmpht_pkg::ACT_ADD: begin
        wr_b = vld_a;
        res_next.collision = (rd_pid != '0) && (rd_pid != req_a.key_pid);
      end
      dmpht_pkg::ACT_REMOVE: begin
        wr_b      = vld_a && (rd_pid == req_a.key_pid);
        wr_zero_b = 1'b1;
      end
      default: begin
        res_next.found_pid     = rd_pid;
        res_next.found_account = dmpht_pkg::ACCT_FIELD_WIDTH'(rd_acct);
      end
    endcase
  end

  // write-back; the sweep only runs while no lookup is in flight
  assign wr_en   = clr.en || wr_b;
  assign wr_addr = clr.en ? clr.addr : idx_a;
  assign wr_pid  = (clr.en || wr_zero_b) ? '0 : req_a.entry_pid;
  assign wr_acct = (clr.en || wr_zero_b) ? '0
                 : req_a.entry_account[dmpht_pkg::ACCOUNT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_pid[wr_addr]  <= wr_pid;
      mem_acct[wr_addr] <= wr_acct;
    end
  end

  // result holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (vld_a) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_a) begin
      res <= res_next;
    end
  end

  a_clr_excl: assert property (@(posedge clk) disable iff (rst) !(clr.en && (look.en || vld_a)))
    else $error("clearing sweep overlaps a lookup");

  a_res_src: assert property (@(posedge clk) disable iff (rst) $rose(res_valid) |-> $past(vld_a))
    else $error("result appeared without a modify stage");

endmodule

// ----- tb/sv/direct_mapped_pid_hash_table_unit_tb.sv -----
// direct_mapped_pid_hash_table_unit_tb: self-checking bench for the pid hash table,
// a mirror of the table and its murmur3 slot hash predicts every result word
// depends on dmpht_pkg and direct_mapped_pid_hash_table_unit

module direct_mapped_pid_hash_table_unit_tb;
  import dmpht_pkg::*;

  // the package names three actions, the fourth code behaves as a get
  localparam logic [ACTION_WIDTH-1:0] ACT_SPARE = 2'd3;

  localparam int unsigned PID_TOP      = 4194304;  // largest pid the bench draws, below the top of the 23-bit field
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned TAIL_CYCLES  = 16;       // quiet stretch at the end before the final check
  localparam int unsigned LONG_HOLD    = 120;

  logic                       clk;
  logic                       rst;
  logic                       req_valid;
  logic                       req_stall;
  req_t                       req;
  logic                       rsp_valid;
  logic                       rsp_stall;
  rsp_t                       rsp;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;

  direct_mapped_pid_hash_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mirror of the block: slot contents and the two registers
  logic [PID_WIDTH-1:0]        pid_mirror  [NUM_SLOTS];
  logic [ACCT_FIELD_WIDTH-1:0] acct_mirror [NUM_SLOTS];
  logic [SEED_WIDTH-1:0]       seed_mirror;
  logic [LOG_SIZE_WIDTH-1:0]   log_mirror;

  // result words predicted at request acceptance, oldest first
  rsp_t        pending_rsp[$];
  int unsigned mismatch_count;

  // bench-side knobs shared between the stimulus and the response side
  bit          jitter_on;      // random gaps on both channels
  int unsigned rsp_hold_len;   // nonzero asks the response side for one long hold
  bit          offering;       // req_valid as last driven by the bench

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // murmur3 x86_32 over one four-byte block: body mix, length, final avalanche
  function automatic logic [31:0] murmur_pid32(input logic [31:0] key,
                                               input logic [31:0] seed);
    logic [31:0] k;
    logic [31:0] h;
    k = key * 32'hcc9e2d51;
    k = {k[16:0], k[31:17]};
    k = k * 32'h1b873593;
    h = seed ^ k;
    h = {h[18:0], h[31:19]};
    h = h * 32'd5 + 32'he6546b64;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // out-of-range log sizes clamp to 1 .. MAX_LOG_SLOTS
  function automatic logic [SLOT_BITS-1:0] slot_for(input logic [PID_WIDTH-1:0] pid);
    logic [31:0] h;
    logic [31:0] mask;
    int unsigned ls;
    h  = murmur_pid32({{(32-PID_WIDTH){1'b0}}, pid}, seed_mirror);
    ls = log_mirror;
    if (ls < 1) ls = 1;
    if (ls > MAX_LOG_SLOTS) ls = MAX_LOG_SLOTS;
    mask = (32'd1 << ls) - 32'd1;
    return h[SLOT_BITS-1:0] & mask[SLOT_BITS-1:0];
  endfunction

  // applies one accepted request to the mirror and returns the word it must produce
  function automatic rsp_t table_outcome(input req_t w);
    rsp_t                 r;
    logic [SLOT_BITS-1:0] ix;
    r  = '0;
    ix = slot_for(w.key_pid);
    r.slot_index = ix;
    case (w.action)
      ACT_ADD: begin
        // collision only against a live pid that differs from the key
        r.collision     = (pid_mirror[ix] != '0) && (pid_mirror[ix] != w.key_pid);
        pid_mirror[ix]  = w.entry_pid;
        acct_mirror[ix] = w.entry_account;
      end
      ACT_REMOVE: begin
        if (pid_mirror[ix] == w.key_pid) begin
          pid_mirror[ix]  = '0;
          acct_mirror[ix] = '0;
        end
      end
      default: begin
        // get, and the spare code acting as get
        r.found_pid     = pid_mirror[ix];
        r.found_account = acct_mirror[ix];
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  function automatic req_t make_req(input logic [ACTION_WIDTH-1:0] act,
                                    input int unsigned key,
                                    input int unsigned epid,
                                    input logic [ACCT_FIELD_WIDTH-1:0] acct);
    req_t w;
    w.action        = act;
    w.key_pid       = key[PID_WIDTH-1:0];
    w.entry_pid     = epid[PID_WIDTH-1:0];
    w.entry_account = acct;
    return w;
  endfunction

  function automatic logic [ACCT_FIELD_WIDTH-1:0] rand_account();
    return {$urandom, $urandom};
  endfunction

  // pid from 0 to PID_TOP with the two ends weighted up
  function automatic int unsigned rand_pid();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 0;
    if (roll == 1) return PID_TOP;
    return $urandom_range(0, PID_TOP);
  endfunction

  // offers one request word and holds it until taken; valid stays up afterwards
  // so a following word can go out on the next edge without a bubble
  task automatic send_word(input req_t w);
    int unsigned gap;
    gap = jitter_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      if (offering) begin
        req_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (req_stall);
    pending_rsp.push_back(table_outcome(w));
  endtask

  // drops valid and waits until every predicted word has come back
  task automatic settle();
    if (offering) begin
      req_valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // writes both registers back to back; only called with the block idle
  task automatic load_config(input logic [SEED_WIDTH-1:0] seed,
                             input logic [CFG_DATA_WIDTH-1:0] log_word);
    cfg_index <= CFG_HASH_SEED;
    cfg_data  <= seed;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    seed_mirror = seed;
    cfg_index <= CFG_LOG_SIZE;
    cfg_data  <= log_word;
    do @(posedge clk); while (!cfg_ready);
    log_mirror = log_word[LOG_SIZE_WIDTH-1:0];
    cfg_valid <= 1'b0;
  endtask

  // log size in the low nibble, noise above it that the block must ignore
  function automatic logic [CFG_DATA_WIDTH-1:0] log_word_of(input int unsigned ls);
    logic [CFG_DATA_WIDTH-1:0] noise;
    noise = $urandom;
    return {noise[CFG_DATA_WIDTH-1:LOG_SIZE_WIDTH], ls[LOG_SIZE_WIDTH-1:0]};
  endfunction

  // mixed traffic over a small set of live pids so adds, hits, removes and
  // collisions meet each other; a share of words use fresh pids as noise
  task automatic random_burst(input int unsigned count, input int unsigned pool_len);
    int unsigned pool[8];
    int unsigned key;
    int unsigned epid;
    int unsigned roll;
    logic [ACTION_WIDTH-1:0] act;
    for (int i = 0; i < 8; i++) pool[i] = rand_pid();
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 9);
      key  = (roll < 8) ? pool[$urandom_range(0, pool_len - 1)] : rand_pid();
      roll = $urandom_range(0, 19);
      if (roll < 8)       act = ACT_ADD;
      else if (roll < 14) act = ACT_GET;
      else if (roll < 19) act = ACT_REMOVE;
      else                act = ACT_SPARE;
      // adds mostly store the key itself, as a real table would
      epid = ($urandom_range(0, 3) != 0) ? key : rand_pid();
      send_word(make_req(act, key, epid, rand_account()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // response side: per-word stall draws, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : rsp_side
    int unsigned n;
    rsp_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rsp_hold_len != 0) begin
        // long hold counted here, the sender keeps offering meanwhile
        rsp_stall <= 1'b1;
        repeat (rsp_hold_len) @(posedge clk);
        rsp_hold_len = 0;
      end
      n = jitter_on ? $urandom_range(0, 3) : 0;
      if (n != 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall) && rsp_hold_len == 0);
    end
  end

  // every accepted result word is matched against the oldest prediction
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("result word with nothing expected: slot_index %0d", rsp.slot_index);
        mismatch_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, actual %0d", want.slot_index, rsp.slot_index);
          mismatch_count++;
        end
        if (rsp.found_pid !== want.found_pid) begin
          $error("found_pid: expected %0h, actual %0h", want.found_pid, rsp.found_pid);
          mismatch_count++;
        end
        if (rsp.found_account !== want.found_account) begin
          $error("found_account: expected %0h, actual %0h",
                 want.found_account, rsp.found_account);
          mismatch_count++;
        end
        if (rsp.collision !== want.collision) begin
          $error("collision: expected %0b, actual %0b", want.collision, rsp.collision);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: generous bound over sweep, latency, gaps and the long hold
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("direct_mapped_pid_hash_table_unit_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // freshly swept table at reset config: everything reads back empty,
  // removing pid zero hits an empty slot and changes nothing
  task automatic test_reset_state();
    jitter_on = 1'b1;
    send_word(make_req(ACT_GET, 0, 0, '0));
    send_word(make_req(ACT_GET, PID_TOP, PID_TOP, '1));
    send_word(make_req(ACT_REMOVE, 0, PID_TOP, '1));
    send_word(make_req(ACT_SPARE, PID_TOP, 0, '0));
    settle();
  endtask

  // two slots in use so a second pid sharing the slot is easy to find
  task automatic test_slot_ops();
    int unsigned a;
    int unsigned b;
    int unsigned c;
    load_config('0, log_word_of(1));
    a = PID_TOP;
    b = 1;
    while (slot_for(b[PID_WIDTH-1:0]) != slot_for(a[PID_WIDTH-1:0])) b++;
    c = b + 1;
    while (slot_for(c[PID_WIDTH-1:0]) != slot_for(a[PID_WIDTH-1:0])) c++;
    send_word(make_req(ACT_ADD, a, a, '1));                        // empty slot, no collision
    send_word(make_req(ACT_GET, a, 0, '0));
    send_word(make_req(ACT_ADD, a, a, '0));                        // same pid rewrites quietly
    send_word(make_req(ACT_ADD, b, b, 64'h5555_5555_5555_5555));   // different live pid
    send_word(make_req(ACT_SPARE, a, 0, '1));                      // spare code reads the slot
    send_word(make_req(ACT_REMOVE, a, 0, '0));                     // pid mismatch keeps entry
    send_word(make_req(ACT_GET, b, 0, '0));
    send_word(make_req(ACT_REMOVE, b, 0, '0));                     // match clears
    send_word(make_req(ACT_GET, b, 0, '0));
    send_word(make_req(ACT_ADD, c, 0, 64'haaaa_aaaa_aaaa_aaaa));   // stores pid zero
    send_word(make_req(ACT_ADD, b, PID_TOP - 1, '1));              // zero pid is no collision
    send_word(make_req(ACT_GET, c, 0, '0));
    settle();
  endtask

  // register extremes, including log sizes below and above the usable range
  task automatic test_config_extremes();
    int unsigned seeds[6];
    int unsigned sizes[6];
    seeds = '{32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0, 32'h0};
    sizes = '{0, 15, 10, 1, 2, 5};
    seeds[4] = $urandom;
    seeds[5] = $urandom;
    for (int i = 0; i < 6; i++) begin
      load_config(seeds[i], log_word_of(sizes[i]));
      random_burst(10, 4);
      settle();
    end
  endtask

  // response side held off long enough that the block backs up into req
  task automatic test_output_stall();
    jitter_on = 1'b0;
    load_config($urandom, log_word_of(3));
    rsp_hold_len = LONG_HOLD;
    random_burst(12, 3);
    settle();
  endtask

  // bulk traffic over several settings, with and without jitter
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      jitter_on = (phase != 1);
      load_config($urandom, log_word_of($urandom_range(0, 15)));
      random_burst(70, (phase == 4) ? 8 : $urandom_range(2, 8));
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin : run
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pid_mirror[i]  = '0;
      acct_mirror[i] = '0;
    end
    seed_mirror    = SEED_RESET;
    log_mirror     = LOG_SIZE_RESET;
    mismatch_count = 0;
    jitter_on      = 1'b0;
    rsp_hold_len   = 0;
    offering       = 1'b0;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // the clearing sweep after reset shows up as req_stall, send_word waits it out
    test_reset_state();
    test_slot_ops();
    test_config_extremes();
    test_output_stall();
    test_random_traffic();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d result words never arrived", pending_rsp.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("direct_mapped_pid_hash_table_unit_tb OK");
    end else begin
      $display("direct_mapped_pid_hash_table_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
